// File: src/vector_rotate_xyz_top_defines.svh
// assertion macros shared by the rotate block
`ifndef VECTOR_ROTATE_XYZ_TOP_DEFINES_SVH
`define VECTOR_ROTATE_XYZ_TOP_DEFINES_SVH

// same-cycle implication, off while reset is low
`define VRX_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked during reset as well
`define VRX_ASSERT_NEXT(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// File: src/vrx_pkg.sv
// shared widths, types and tables of the rotate block
`default_nettype none

package vrx_pkg;

  // coordinate and angle formats (coordinates carry 16 fraction bits)
  localparam int COORD_W = 32;
  localparam int ANGLE_W = 16;

  // cordic core: 30 fraction bits, a few guard bits for growth
  localparam int CORDIC_STAGES = 16;
  localparam int ATAN_COUNT    = 24;
  localparam int CORDIC_N      = (CORDIC_STAGES < ATAN_COUNT) ? CORDIC_STAGES : ATAN_COUNT;
  localparam int CORE_FRAC     = 30;
  localparam int CORE_W        = CORE_FRAC + 3;
  localparam int GAIN_INV      = 652032874;

  // sine and cosine format, and the product path
  localparam int TRIG_FRAC = 61 - COORD_W;
  localparam int TRIG_W    = TRIG_FRAC + 2;
  localparam int RND_W     = CORE_W + 16;
  localparam int PROD_W    = COORD_W + TRIG_W;
  localparam int SUM_W     = PROD_W + 1;

  // pipeline depths
  localparam int CORDIC_LAT = CORDIC_N + 2;
  localparam int ROT_LAT    = 2;
  localparam int TOTAL_LAT  = CORDIC_LAT + 3 * ROT_LAT;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [ANGLE_W-1:0] angle_t;
  typedef logic signed [CORE_W-1:0]  core_t;
  typedef logic signed [TRIG_W-1:0]  trig_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } coord_vec_t;

  // cosine, sine and the zero-angle bypass flag of one axis
  typedef struct packed {
    trig_t c;
    trig_t s;
    logic  skip;
  } trig_pair_t;

  // atan(2^-i) in turn units, 2^32 per full turn
  function automatic core_t atan_turn(input int unsigned idx);
    core_t v;
    unique case (idx)
      0:  v = core_t'(32'h20000000);
      1:  v = core_t'(32'h12E4051E);
      2:  v = core_t'(32'h09FB385B);
      3:  v = core_t'(32'h051111D4);
      4:  v = core_t'(32'h028B0D43);
      5:  v = core_t'(32'h0145D7E1);
      6:  v = core_t'(32'h00A2F61E);
      7:  v = core_t'(32'h00517C55);
      8:  v = core_t'(32'h0028BE53);
      9:  v = core_t'(32'h00145F2F);
      10: v = core_t'(32'h000A2F98);
      11: v = core_t'(32'h000517CC);
      12: v = core_t'(32'h00028BE6);
      13: v = core_t'(32'h000145F3);
      14: v = core_t'(32'h0000A2FA);
      15: v = core_t'(32'h0000517D);
      16: v = core_t'(32'h000028BE);
      17: v = core_t'(32'h0000145F);
      18: v = core_t'(32'h00000A30);
      19: v = core_t'(32'h00000518);
      20: v = core_t'(32'h0000028C);
      21: v = core_t'(32'h00000146);
      22: v = core_t'(32'h000000A3);
      23: v = core_t'(32'h00000051);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

// File: src/vrx_cordic.sv
// pipelined sine and cosine of one binary angle
`default_nettype none

module vrx_cordic import vrx_pkg::*; (
  input  logic       clk,
  input  angle_t     angle,
  output trig_pair_t trig
);

  localparam logic signed [RND_W-1:0] TRIG_LIM = RND_W'(1) <<< TRIG_FRAC;

  logic [31:0] turn;
  logic        flip_in;
  core_t       z_in;

  core_t x_r    [CORDIC_N+1];
  core_t y_r    [CORDIC_N+1];
  core_t z_r    [CORDIC_N+1];
  logic  flip_r [CORDIC_N+1];
  logic  zero_r [CORDIC_N+1];

  core_t                    vx, vy;
  logic signed [RND_W-1:0]  rnd_x, rnd_y;
  logic signed [RND_W-1:0]  cl_x, cl_y;
  trig_pair_t               trig_r;

  // fold the angle into the right half plane, remember the flip
  assign turn    = {angle, {(32-ANGLE_W){1'b0}}};
  assign flip_in = turn[31] ^ turn[30];
  assign z_in    = core_t'($signed({turn[30], turn[30:0]}));

  always_ff @(posedge clk) begin
    x_r[0]    <= core_t'(GAIN_INV);
    y_r[0]    <= '0;
    z_r[0]    <= z_in;
    flip_r[0] <= flip_in;
    zero_r[0] <= (angle == '0);
    for (int i = 0; i < CORDIC_N; i++) begin
      if (!z_r[i][CORE_W-1]) begin
        x_r[i+1] <= x_r[i] - (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] + (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] - atan_turn(i);
      end else begin
        x_r[i+1] <= x_r[i] + (y_r[i] >>> i);
        y_r[i+1] <= y_r[i] - (x_r[i] >>> i);
        z_r[i+1] <= z_r[i] + atan_turn(i);
      end
      flip_r[i+1] <= flip_r[i];
      zero_r[i+1] <= zero_r[i];
    end
  end

  assign vx = flip_r[CORDIC_N] ? -x_r[CORDIC_N] : x_r[CORDIC_N];
  assign vy = flip_r[CORDIC_N] ? -y_r[CORDIC_N] : y_r[CORDIC_N];

  // rescale to the product format
  if (TRIG_FRAC >= CORE_FRAC) begin : g_up
    assign rnd_x = RND_W'(vx) <<< (TRIG_FRAC - CORE_FRAC);
    assign rnd_y = RND_W'(vy) <<< (TRIG_FRAC - CORE_FRAC);
  end else begin : g_dn
    localparam int DN = CORE_FRAC - TRIG_FRAC;
    localparam logic signed [RND_W-1:0] RND_HALF = RND_W'(1) <<< (DN - 1);
    assign rnd_x = (RND_W'(vx) + RND_HALF) >>> DN;
    assign rnd_y = (RND_W'(vy) + RND_HALF) >>> DN;
  end

  always_comb begin
    cl_x = rnd_x;
    cl_y = rnd_y;
    if (rnd_x > TRIG_LIM)  cl_x = TRIG_LIM;
    if (rnd_x < -TRIG_LIM) cl_x = -TRIG_LIM;
    if (rnd_y > TRIG_LIM)  cl_y = TRIG_LIM;
    if (rnd_y < -TRIG_LIM) cl_y = -TRIG_LIM;
  end

  always_ff @(posedge clk) begin
    trig_r.c    <= trig_t'(cl_x);
    trig_r.s    <= trig_t'(cl_y);
    trig_r.skip <= zero_r[CORDIC_N];
  end

  assign trig = trig_r;

endmodule

`default_nettype wire

// File: src/vrx_rot.sv
// one plane rotation: products, then round and saturate
`default_nettype none

module vrx_rot import vrx_pkg::*; (
  input  logic       clk,
  input  coord_t     a_in,
  input  coord_t     b_in,
  input  coord_t     pass_in,
  input  trig_pair_t trig,
  output coord_t     a_out,
  output coord_t     b_out,
  output coord_t     pass_out
);

  localparam logic signed [SUM_W-1:0] RND_HALF = SUM_W'(1) <<< (TRIG_FRAC - 1);
  localparam logic signed [SUM_W-1:0] COORD_MAX =
    SUM_W'($signed({1'b0, {(COORD_W-1){1'b1}}}));
  localparam logic signed [SUM_W-1:0] COORD_MIN =
    SUM_W'($signed({1'b1, {(COORD_W-1){1'b0}}}));

  logic signed [PROD_W-1:0] p_ac_r, p_bs_r, p_as_r, p_bc_r;
  coord_t                   a_r, b_r, pass_r;
  logic                     skip_r;

  logic signed [SUM_W-1:0]  sum_a, sum_b;
  coord_t                   a_out_r, b_out_r, pass_out_r;

  function automatic coord_t sat_coord(input logic signed [SUM_W-1:0] v);
    coord_t r;
    if (v > COORD_MAX) begin
      r = coord_t'(COORD_MAX);
    end else if (v < COORD_MIN) begin
      r = coord_t'(COORD_MIN);
    end else begin
      r = coord_t'(v);
    end
    return r;
  endfunction

  // stage 1: four products
  always_ff @(posedge clk) begin
    p_ac_r <= PROD_W'(a_in) * PROD_W'(trig.c);
    p_bs_r <= PROD_W'(b_in) * PROD_W'(trig.s);
    p_as_r <= PROD_W'(a_in) * PROD_W'(trig.s);
    p_bc_r <= PROD_W'(b_in) * PROD_W'(trig.c);
    a_r    <= a_in;
    b_r    <= b_in;
    pass_r <= pass_in;
    skip_r <= trig.skip;
  end

  assign sum_a = (SUM_W'(p_ac_r) - SUM_W'(p_bs_r) + RND_HALF) >>> TRIG_FRAC;
  assign sum_b = (SUM_W'(p_as_r) + SUM_W'(p_bc_r) + RND_HALF) >>> TRIG_FRAC;

  // stage 2: round, saturate, or bypass on a zero angle
  always_ff @(posedge clk) begin
    a_out_r    <= skip_r ? a_r : sat_coord(sum_a);
    b_out_r    <= skip_r ? b_r : sat_coord(sum_b);
    pass_out_r <= pass_r;
  end

  assign a_out    = a_out_r;
  assign b_out    = b_out_r;
  assign pass_out = pass_out_r;

endmodule

`default_nettype wire

// File: src/vector_rotate_xyz_top.sv
// top level of the euler-angle point rotator
//
// usage
//   an item (point plus three angles) is taken at a rising edge with start
//   high and busy low; busy is high only while reset is applied and in the
//   cycle after, so after reset the block takes one item every clock
//   the point is rotated about x, then y, then z; an axis with a zero angle
//   leaves the point as it is; each axis saturates to the coordinate range
//   path: each item goes through the cordic pipeline (16 micro-rotations
//   plus the angle fold and the rescale), then through the multiply and
//   round registers of each axis
//   throughput: one item per clock, set by one micro-rotation per stage and
//   one multiplier stage per axis
//   results: out_valid marks the single cycle in which out_rotated_* hold a
//   result; the receiver has no way to hold results off, the pipeline never
//   stops
//   reset (synchronous, active low) clears the valid line, so no result
//   comes out of items that were in flight
`default_nettype none
`include "vector_rotate_xyz_top_defines.svh"

module vector_rotate_xyz_top import vrx_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  // command side
  input  logic   start,
  output logic   busy,
  input  coord_t in_point_x,
  input  coord_t in_point_y,
  input  coord_t in_point_z,
  input  angle_t in_angle_about_x,
  input  angle_t in_angle_about_y,
  input  angle_t in_angle_about_z,
  // result side
  output logic   out_valid,
  output coord_t out_rotated_x,
  output coord_t out_rotated_y,
  output coord_t out_rotated_z
);

  logic                  busy_r;
  logic                  accept;
  logic [TOTAL_LAT-1:0]  vld_r;

  // point waits here while the angles go through the cordic
  coord_vec_t pt_r [CORDIC_LAT];

  // y and z angles enter their cordic later, lined up with their axis
  angle_t ay_r [ROT_LAT];
  angle_t az_r [2*ROT_LAT];

  trig_pair_t trig_x, trig_y, trig_z;

  // axis outputs: after x, after y, after z
  coord_t x0, y1, z1;
  coord_t x2, z2, y1d;
  coord_t x3, y3, z2d;

  assign accept = start && !busy_r;
  assign busy   = busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
      vld_r  <= '0;
    end else begin
      busy_r <= 1'b0;
      vld_r  <= {vld_r[TOTAL_LAT-2:0], accept};
    end
  end

  // payload delay lines, no reset needed
  always_ff @(posedge clk) begin
    pt_r[0] <= '{x: in_point_x, y: in_point_y, z: in_point_z};
    for (int i = 1; i < CORDIC_LAT; i++) begin
      pt_r[i] <= pt_r[i-1];
    end
    ay_r[0] <= in_angle_about_y;
    for (int i = 1; i < ROT_LAT; i++) begin
      ay_r[i] <= ay_r[i-1];
    end
    az_r[0] <= in_angle_about_z;
    for (int i = 1; i < 2*ROT_LAT; i++) begin
      az_r[i] <= az_r[i-1];
    end
  end

  vrx_cordic u_cordic_x (
    .clk   (clk),
    .angle (in_angle_about_x),
    .trig  (trig_x)
  );

  vrx_cordic u_cordic_y (
    .clk   (clk),
    .angle (ay_r[ROT_LAT-1]),
    .trig  (trig_y)
  );

  vrx_cordic u_cordic_z (
    .clk   (clk),
    .angle (az_r[2*ROT_LAT-1]),
    .trig  (trig_z)
  );

  // about x: y and z turn, x passes
  vrx_rot u_rot_x (
    .clk      (clk),
    .a_in     (pt_r[CORDIC_LAT-1].y),
    .b_in     (pt_r[CORDIC_LAT-1].z),
    .pass_in  (pt_r[CORDIC_LAT-1].x),
    .trig     (trig_x),
    .a_out    (y1),
    .b_out    (z1),
    .pass_out (x0)
  );

  // about y: x and z turn, y passes
  vrx_rot u_rot_y (
    .clk      (clk),
    .a_in     (x0),
    .b_in     (z1),
    .pass_in  (y1),
    .trig     (trig_y),
    .a_out    (x2),
    .b_out    (z2),
    .pass_out (y1d)
  );

  // about z: x and y turn, z passes
  vrx_rot u_rot_z (
    .clk      (clk),
    .a_in     (x2),
    .b_in     (y1d),
    .pass_in  (z2),
    .trig     (trig_z),
    .a_out    (x3),
    .b_out    (y3),
    .pass_out (z2d)
  );

  assign out_valid     = vld_r[TOTAL_LAT-1];
  assign out_rotated_x = x3;
  assign out_rotated_y = y3;
  assign out_rotated_z = z2d;

  // a result strobe always goes back to an accepted item
  `VRX_ASSERT_IMP(a_out_from_accept, clk, rst_n, out_valid, $past(accept, TOTAL_LAT), "result without an item")

  // all three angles zero: the point comes out untouched
  `VRX_ASSERT_IMP(a_zero_pass, clk, rst_n, out_valid && $past(in_angle_about_x == '0 && in_angle_about_y == '0 && in_angle_about_z == '0, TOTAL_LAT), out_rotated_x == $past(in_point_x, TOTAL_LAT) && out_rotated_y == $past(in_point_y, TOTAL_LAT) && out_rotated_z == $past(in_point_z, TOTAL_LAT), "zero angles changed the point")

  // reset drops any item in flight and holds off new ones
  `VRX_ASSERT_NEXT(a_reset_quiet, clk, !rst_n, !out_valid && busy, "result or accept right after reset")

endmodule

`default_nettype wire

// File: tb/vector_rotate_xyz_top_tb.sv
// self-checking testbench of the euler-angle point rotator
`timescale 1ns / 100ps

module vector_rotate_xyz_top_tb;
  import vrx_pkg::*;

  // cycles with no item taken and no result seen before the run is declared hung
  localparam int HANG_LIMIT = 500;
  localparam int RANDOM_ITEMS = 850;

  // expected rotations of accepted items, in order, and their comparison
  class rotate_scoreboard;
    coord_vec_t expected_q[$];
    int unsigned noted_count;
    int unsigned checked_count;
    int unsigned error_count;

    // atan(2^-i) in turn units, 2^32 per turn
    longint atan_lut[24] = '{
      64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
      64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
      64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
      64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
      64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051
    };

    function automatic longint clamp(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // cosine and sine of a binary angle, TRIG_FRAC fraction bits
    function automatic void sin_cos(input angle_t ang, output longint c, output longint s);
      bit [31:0] turn;
      bit        fold;
      longint    x, y, z, t, lim;
      int        d;
      turn = {ang, {(32 - ANGLE_W){1'b0}}};
      // second and third quadrant: turn by pi, negate at the end
      fold = (turn[31:30] == 2'd1) || (turn[31:30] == 2'd2);
      if (fold) turn = turn + 32'h80000000;
      z = longint'($signed(turn));
      x = GAIN_INV;
      y = 0;
      for (int i = 0; i < CORDIC_N; i++) begin
        if (z >= 0) begin
          t = x - (y >>> i);
          y = y + (x >>> i);
          z = z - atan_lut[i];
        end else begin
          t = x + (y >>> i);
          y = y - (x >>> i);
          z = z + atan_lut[i];
        end
        x = t;
      end
      if (fold) begin
        x = -x;
        y = -y;
      end
      d = CORE_FRAC - TRIG_FRAC;
      if (d > 0) begin
        // round half up on the way down
        c = (x + (64'sd1 <<< (d - 1))) >>> d;
        s = (y + (64'sd1 <<< (d - 1))) >>> d;
      end else begin
        c = x <<< (-d);
        s = y <<< (-d);
      end
      lim = 64'sd1 <<< TRIG_FRAC;
      c = clamp(c, -lim, lim);
      s = clamp(s, -lim, lim);
    endfunction

    function automatic longint round_sat(longint p, longint q);
      longint hi, v;
      hi = (64'sd1 <<< (COORD_W - 1)) - 1;
      v = (p + q + (64'sd1 <<< (TRIG_FRAC - 1))) >>> TRIG_FRAC;
      return clamp(v, -hi - 1, hi);
    endfunction

    // one plane rotation, skipped for a zero angle
    function automatic void turn_plane(inout longint a, inout longint b, input angle_t ang);
      longint c, s, na, nb;
      if (ang == 0) return;
      sin_cos(ang, c, s);
      na = round_sat(a * c, -(b * s));
      nb = round_sat(a * s, b * c);
      a = na;
      b = nb;
    endfunction

    function void note_item(coord_t px, coord_t py, coord_t pz,
                            angle_t ax, angle_t ay, angle_t az);
      longint x, y, z;
      coord_vec_t v;
      x = px;
      y = py;
      z = pz;
      turn_plane(y, z, ax);
      turn_plane(x, z, ay);
      turn_plane(x, y, az);
      v.x = coord_t'(x);
      v.y = coord_t'(y);
      v.z = coord_t'(z);
      expected_q.push_back(v);
      noted_count++;
    endfunction

    function void check_result(coord_t rx, coord_t ry, coord_t rz);
      coord_vec_t e;
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, got x %0d y %0d z %0d",
                 $time, rx, ry, rz);
        error_count++;
        return;
      end
      e = expected_q.pop_front();
      checked_count++;
      if (rx !== e.x) begin
        $display("%0t: rotated_x mismatch, expected %0d, actual %0d", $time, e.x, rx);
        error_count++;
      end
      if (ry !== e.y) begin
        $display("%0t: rotated_y mismatch, expected %0d, actual %0d", $time, e.y, ry);
        error_count++;
      end
      if (rz !== e.z) begin
        $display("%0t: rotated_z mismatch, expected %0d, actual %0d", $time, e.z, rz);
        error_count++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic   clk;
  logic   rst_n;
  logic   start;
  logic   busy;
  coord_t in_point_x;
  coord_t in_point_y;
  coord_t in_point_z;
  angle_t in_angle_about_x;
  angle_t in_angle_about_y;
  angle_t in_angle_about_z;
  logic   out_valid;
  coord_t out_rotated_x;
  coord_t out_rotated_y;
  coord_t out_rotated_z;

  rotate_scoreboard rot_sb = new();
  int unsigned idle_cycles;
  int unsigned zero_angle_items;

  vector_rotate_xyz_top u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_point_x        (in_point_x),
    .in_point_y        (in_point_y),
    .in_point_z        (in_point_z),
    .in_angle_about_x  (in_angle_about_x),
    .in_angle_about_y  (in_angle_about_y),
    .in_angle_about_z  (in_angle_about_z),
    .out_valid         (out_valid),
    .out_rotated_x     (out_rotated_x),
    .out_rotated_y     (out_rotated_y),
    .out_rotated_z     (out_rotated_z)
  );

  // 2 ns clock
  initial clk = 1'b0;
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // monitor: values seen here are the ones before the edge, so an item is
  // taken when start was high and busy low, and a result when out_valid was high
  always @(posedge clk) begin
    if (start === 1'b1 && busy === 1'b0) begin
      rot_sb.note_item(in_point_x, in_point_y, in_point_z,
                       in_angle_about_x, in_angle_about_y, in_angle_about_z);
      if (in_angle_about_x == 0 || in_angle_about_y == 0 || in_angle_about_z == 0)
        zero_angle_items++;
    end
    if (out_valid === 1'b1)
      rot_sb.check_result(out_rotated_x, out_rotated_y, out_rotated_z);

    // watchdog: any handshake counts as progress
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= HANG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, HANG_LIMIT);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // put one item on the command side and hold it until the block takes it;
  // returns right after the accepting edge, start still high
  task automatic send_item(coord_t px, coord_t py, coord_t pz,
                           angle_t ax, angle_t ay, angle_t az);
    start            <= 1'b1;
    in_point_x       <= px;
    in_point_y       <= py;
    in_point_z       <= pz;
    in_angle_about_x <= ax;
    in_angle_about_y <= ay;
    in_angle_about_z <= az;
    do @(posedge clk); while (busy !== 1'b0);
  endtask

  // sender gap: start low, noise on the fields, which must be ignored
  task automatic hold_off(int unsigned cycles);
    for (int unsigned i = 0; i < cycles; i++) begin
      start            <= 1'b0;
      in_point_x       <= coord_t'($urandom);
      in_point_y       <= coord_t'($urandom);
      in_point_z       <= coord_t'($urandom);
      in_angle_about_x <= angle_t'($urandom);
      in_angle_about_y <= angle_t'($urandom);
      in_angle_about_z <= angle_t'($urandom);
      @(posedge clk);
    end
  endtask

  // drop start and wait for every outstanding rotation to come back
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (rot_sb.pending() != 0) @(posedge clk);
  endtask

  // coordinates: full range half of the time, with small values and extremes
  function automatic coord_t pick_coord();
    case ($urandom_range(0, 9))
      0:       return coord_t'({1'b0, {(COORD_W-1){1'b1}}});
      1:       return coord_t'({1'b1, {(COORD_W-1){1'b0}}});
      2:       return coord_t'($urandom_range(0, 3)) - coord_t'(1);
      3, 4:    return coord_t'(int'($urandom_range(0, 2097151)) - 1048576);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // angles: zero often enough to exercise the bypass, quadrant edges, random
  function automatic angle_t pick_angle();
    case ($urandom_range(0, 11))
      0, 1:    return '0;
      2:       return angle_t'(16'h8000);
      3:       return angle_t'(16'h4000);
      4:       return angle_t'(16'hC000);
      5:       return angle_t'($urandom_range(0, 2)) + angle_t'(16'h3FFF);
      6:       return angle_t'($urandom_range(0, 2)) + angle_t'(16'hBFFF);
      7:       return angle_t'($urandom_range(0, 2)) - angle_t'(1);
      default: return angle_t'($urandom);
    endcase
  endfunction

  initial begin
    coord_t cmax, cmin, one;
    int unsigned sent;
    int unsigned burst;

    cmax = {1'b0, {(COORD_W-1){1'b1}}};
    cmin = {1'b1, {(COORD_W-1){1'b0}}};
    one  = coord_t'(32'h0001_0000);

    // every input known from time zero
    rst_n            = 1'b0;
    start            = 1'b0;
    in_point_x       = '0;
    in_point_y       = '0;
    in_point_z       = '0;
    in_angle_about_x = '0;
    in_angle_about_y = '0;
    in_angle_about_z = '0;
    idle_cycles      = 0;
    zero_angle_items = 0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // directed part, back to back
    // all angles zero: pure pass-through, extremes included
    send_item('0, '0, '0, '0, '0, '0);
    send_item(cmax, cmin, cmax, '0, '0, '0);
    send_item(cmin, cmax, coord_t'(-1), '0, '0, '0);
    // quarter turns, one axis at a time, then all three at once
    send_item('0, one, '0, angle_t'(16'h4000), '0, '0);
    send_item(one, '0, '0, '0, angle_t'(16'h4000), '0);
    send_item(one, '0, '0, '0, '0, angle_t'(16'h4000));
    send_item(one, one, one, angle_t'(16'hC000), angle_t'(16'hC000), angle_t'(16'hC000));
    // angle of minus pi on every axis
    send_item(one, coord_t'(2 * 65536), coord_t'(3 * 65536),
              angle_t'(16'h8000), angle_t'(16'h8000), angle_t'(16'h8000));
    // eighth turns on full-scale points: each axis saturates on its own
    send_item(cmax, cmax, cmax, angle_t'(16'h2000), angle_t'(16'h2000), angle_t'(16'h2000));
    send_item(cmin, cmin, cmin, angle_t'(16'h2000), angle_t'(16'h2000), angle_t'(16'h2000));
    send_item(cmax, cmin, cmax, angle_t'(16'hE000), angle_t'(16'h6000), angle_t'(16'hA000));
    // largest and smallest nonzero angles
    send_item(cmax, cmin, one, angle_t'(16'h7FFF), angle_t'(16'hFFFF), angle_t'(16'h0001));
    // quadrant boundaries of the angle fold
    send_item(one, one, one, angle_t'(16'h3FFF), angle_t'(16'h4001), angle_t'(16'hBFFF));
    send_item(one, one, one, angle_t'(16'hC001), angle_t'(16'h7FFF), angle_t'(16'h8001));
    // single lsb coordinates
    send_item(coord_t'(1), coord_t'(-1), coord_t'(1),
              angle_t'(16'h1234), angle_t'(16'hA5A5), angle_t'(16'h5A5A));
    // arbitrary values with every bit pattern mixed
    send_item(coord_t'(32'h1234_5678), coord_t'(32'h8765_4321), coord_t'(32'hDEAD_BEEF),
              angle_t'(16'd1234), angle_t'(-16'sd5678), angle_t'(16'd30000));
    send_item(coord_t'(32'h5555_5555), coord_t'(32'hAAAA_AAAA), coord_t'(32'h7F00_00FF),
              angle_t'(16'h5555), angle_t'(16'hAAAA), '0);

    // let the pipeline run dry before the random part
    drain_results();

    // random part: bursts of back-to-back items with random gaps between
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = $urandom_range(1, 40);
      for (int unsigned k = 0; k < burst && sent < RANDOM_ITEMS; k++) begin
        send_item(pick_coord(), pick_coord(), pick_coord(),
                  pick_angle(), pick_angle(), pick_angle());
        sent++;
      end
      // mid-run drain, then ordinary gaps, sometimes none at all
      if (sent >= RANDOM_ITEMS / 2 && sent - burst < RANDOM_ITEMS / 2)
        drain_results();
      else if ($urandom_range(0, 3) != 0)
        hold_off($urandom_range(1, 12));
    end

    // end of stimulus: wait for the last results, then let the clock run on with start low
    drain_results();
    repeat (TOTAL_LAT + 8) @(posedge clk);

    $display("run covered %0d items, %0d of them with at least one zero angle",
             rot_sb.noted_count, zero_angle_items);
    $display("%0d rotations checked, %0d mismatches", rot_sb.checked_count,
             rot_sb.error_count);
    if (rot_sb.error_count == 0 && rot_sb.pending() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// File: sim.f
+incdir+src
src/vrx_pkg.sv
src/vrx_cordic.sv
src/vrx_rot.sv
src/vector_rotate_xyz_top.sv
tb/vector_rotate_xyz_top_tb.sv
